// ===== rtl/core/esm_pkg.sv =====
// esm_pkg: sizes, command codes and cell control type for the substring matcher
// used by esm_cell and exact_substring_match_stream; no dependencies
package esm_pkg;

   localparam int MAX_QUERY = 64;
   localparam int POS_BITS  = 32;

   localparam int CMD_W  = 2;
   localparam int IDX_W  = 6;
   localparam int SYM_W  = 8;
   localparam int LEN_W  = 7;
   localparam int OUT_W  = 32;

   localparam int QIDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int CNT_W  = $clog2(MAX_QUERY + 1);
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int LDI_W  = ((QIDX_W > IDX_W) ? QIDX_W : IDX_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_TEXT  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic clear;
      logic shift;
      logic rotate;
   } cell_ctl_type;

endpackage

// ===== rtl/core/esm_cell.sv =====
// esm_cell: one window byte and one query byte with their equality flag
// depends on esm_pkg
module esm_cell
   import esm_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [SYM_W-1:0]   shift_in,
   input  logic [SYM_W-1:0]   rot_in,
   input  logic               load_en,
   input  logic [SYM_W-1:0]   load_byte,
   output logic [SYM_W-1:0]   win_out,
   output logic [SYM_W-1:0]   qry_out,
   output logic               eq
);

   logic [SYM_W-1:0] win_ff, win_in;
   logic [SYM_W-1:0] qry_ff, qry_in;

   always_comb begin
      priority if (ctl.clear) begin
         win_in = '0;
      end else if (ctl.shift) begin
         win_in = shift_in;
      end else begin
         win_in = win_ff;
      end
   end

   always_comb begin
      priority if (ctl.rotate) begin
         qry_in = rot_in;
      end else if (load_en) begin
         qry_in = load_byte;
      end else begin
         qry_in = qry_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      qry_ff <= qry_in;
   end

   assign win_out = win_ff;
   assign qry_out = qry_ff;
   assign eq      = (win_ff == qry_ff);

endmodule

// ===== rtl/core/exact_substring_match_stream.sv =====
// exact_substring_match_stream: streamed exact substring search over a row of cells
// depends on esm_pkg and esm_cell
// a matching text beat is registered into the window row and pend flag, then its result into rsp_valid
// throughput: one beat per cycle while rsp_ready stays high and the query row is not rotating
// a length write stalls req_ready while the query row rotates
// reset (synchronous): empty window, position zero, length one, no result pending
module exact_substring_match_stream
   import esm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [IDX_W-1:0]   req_char_index,
   input  logic [SYM_W-1:0]   req_symbol,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OUT_W-1:0]   rsp_match_start,
   input  logic               csr_wr_en,
   input  logic [LEN_W-1:0]   csr_wr_data
);

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   logic [LEN_W-1:0]     len_ff, len_in;
   logic [QIDX_W-1:0]    align_ff, align_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 pend_ff, pend_in;
   logic [OUT_W-1:0]     start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_start_ff, rsp_start_in;

   logic                 len_ok;
   logic [QIDX_W-1:0]    align_target;
   logic                 busy;
   logic                 s1_go;
   logic                 accept;
   cmd_type              cmd;
   logic                 is_text;
   logic                 is_start;
   logic                 is_load;
   logic [CNT_W-1:0]     fill_next;
   logic [LDI_W-1:0]     ld_diff;
   logic [QIDX_W-1:0]    ld_cell;
   logic                 ld_ok;
   logic [POS_BITS-1:0]  start_pos;
   logic                 all_eq;
   cell_ctl_type         ctl;

   logic [SYM_W-1:0]     win_bus [MAX_QUERY];
   logic [SYM_W-1:0]     qry_bus [MAX_QUERY];
   logic [MAX_QUERY-1:0] eq_bits;
   logic [MAX_QUERY-1:0] active;
   logic [MAX_QUERY-1:0] ld_sel;

   // query length checks and row alignment
   assign len_ok = (len_ff != '0) && (CMP_W'(len_ff) <= CMP_W'(MAX_QUERY));

   always_comb begin
      align_target = align_ff;
      if (len_ok) begin
         if (CMP_W'(len_ff) == CMP_W'(MAX_QUERY)) begin
            align_target = '0;
         end else begin
            align_target = QIDX_W'(len_ff);
         end
      end
   end

   assign busy = (align_ff != align_target);

   always_comb begin
      align_in = align_ff;
      if (busy) begin
         if (align_ff == QIDX_W'(MAX_QUERY - 1)) begin
            align_in = '0;
         end else begin
            align_in = align_ff + QIDX_W'(1);
         end
      end
   end

   // handshake
   assign s1_go     = !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy && (!pend_ff || s1_go);
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);

   always_comb begin
      is_text  = 1'b0;
      is_start = 1'b0;
      is_load  = 1'b0;
      unique case (cmd)
         CMD_START: is_start = accept;
         CMD_LOAD:  is_load  = accept;
         CMD_TEXT:  is_text  = accept;
         CMD_NONE:  ;
         default:   ;
      endcase
   end

   // query load addressing: cell j holds query byte (j + align) mod MAX_QUERY
   always_comb begin
      ld_ok   = (LDI_W'(req_char_index) < LDI_W'(MAX_QUERY));
      ld_diff = LDI_W'(req_char_index) - LDI_W'(align_ff);
      if (ld_diff[LDI_W-1]) begin
         ld_diff = ld_diff + LDI_W'(MAX_QUERY);
      end
      ld_cell = ld_diff[QIDX_W-1:0];
   end

   // window fill and position
   assign fill_next = (CMP_W'(fill_ff) < CMP_W'(MAX_QUERY)) ? fill_ff + CNT_W'(1) : fill_ff;
   assign start_pos = pos_ff + POS_BITS'(1) - POS_BITS'(len_ff);

   always_comb begin
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      pend_in  = pend_ff;
      start_in = start_ff;
      if (pend_ff && s1_go) begin
         pend_in = 1'b0;
      end
      if (is_start) begin
         fill_in = '0;
         pos_in  = '0;
      end else if (is_text) begin
         fill_in = fill_next;
         if (pos_ff != POS_MAX) begin
            pos_in   = pos_ff + POS_BITS'(1);
            pend_in  = len_ok && (CMP_W'(fill_next) >= CMP_W'(len_ff));
            start_in = OUT_W'(start_pos);
         end
      end
   end

   assign ctl = '{clear: is_start, shift: is_text, rotate: busy};

   // row of cells
   for (genvar j = 0; j < MAX_QUERY; j++) begin : g_cell
      localparam logic [CMP_W-1:0] THR = CMP_W'(MAX_QUERY - j);
      localparam int NXT = (j + 1) % MAX_QUERY;
      logic [SYM_W-1:0] shift_src;

      if (j == MAX_QUERY - 1) begin : g_tail
         assign shift_src = req_symbol;
      end else begin : g_body
         assign shift_src = win_bus[NXT];
      end

      assign ld_sel[j] = is_load && ld_ok && (ld_cell == QIDX_W'(j));
      assign active[j] = (CMP_W'(len_ff) >= THR);

      esm_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .shift_in  (shift_src),
         .rot_in    (qry_bus[NXT]),
         .load_en   (ld_sel[j]),
         .load_byte (req_symbol),
         .win_out   (win_bus[j]),
         .qry_out   (qry_bus[j]),
         .eq        (eq_bits[j])
      );
   end

   assign all_eq = &(eq_bits | ~active);

   // result register
   always_comb begin
      priority if (pend_ff && s1_go) begin
         rsp_valid_in = all_eq;
         rsp_start_in = start_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
         rsp_start_in = rsp_start_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
         rsp_start_in = rsp_start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_W'(1);
         align_ff     <= QIDX_W'(1);
         pos_ff       <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         align_ff     <= align_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign len_in = csr_wr_en ? csr_wr_data : len_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_start = rsp_start_ff;

endmodule
